>>> rtl/core/lmfd_pkg.sv
`default_nettype none
package lmfd_pkg;

	localparam int LENGTH_BITS = 16;
	localparam logic [15:0] LEN_MASK = 16'((32'd1 << LENGTH_BITS) - 32'd1);

	typedef enum logic [2:0] {
		PH_HDR0 = 3'd0,
		PH_HDR1 = 3'd1,
		PH_LEN0 = 3'd2,
		PH_LEN1 = 3'd3,
		PH_PAY  = 3'd4,
		PH_FTR0 = 3'd5,
		PH_FTR1 = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		K_PAY  = 2'd0,
		K_GOOD = 2'd1,
		K_BAD  = 2'd2,
		K_DROP = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		logic [15:0] frame_length;
		logic        first_frame;
	} res_t;

endpackage
`default_nettype wire

>>> rtl/core/learned_marker_frame_deframer_core.sv
`default_nettype none
// Header / length / footer deframer with learned markers.
//
// Upstream channel (up_valid, up_stall, data_byte): one raw stream byte per
// word. Downstream channel (dn_valid, dn_stall, kind, out_byte,
// frame_length, first_frame): zero or one result word per input byte.
// A frame is a 2-byte header, a little-endian length, the payload and a
// 2-byte footer. The first frame after reset sets the header and footer
// markers; later frames are checked against them.
// A byte is registered in the input register on acceptance, and the parser
// steps on it once its result has somewhere to go. Its result (if any) is then
// loaded into the output register, which drives dn_valid. Throughput is one
// byte per clock while the receiver does not stall.
// Reset clears the parser to "waiting for header", forgets the learned
// markers and empties both registers. When the receiver stalls, the output
// register holds; a byte that gives no result still passes through, and a
// byte that needs the held output register waits in the input register,
// which raises up_stall.
module learned_marker_frame_deframer_core (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              up_valid,
	output logic             up_stall,
	input  wire  [7:0]       data_byte,
	output logic             dn_valid,
	input  wire              dn_stall,
	output logic [1:0]       kind,
	output logic [7:0]       out_byte,
	output logic [15:0]      frame_length,
	output logic             first_frame
);
	import lmfd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       has_res;
	logic       out_free;
	logic       go;
	res_t       res;
	res_t       res_out;

	// Parser steps when a byte is held and its result has somewhere to go.
	assign go       = valid_s1 & (~has_res | out_free);
	assign up_stall = valid_s1 & ~go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!up_stall) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && !up_stall)
			byte_s1 <= data_byte;
	end

	lmfd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.byte_s1 (byte_s1),
		.has_res (has_res),
		.res     (res)
	);

	lmfd_outreg u_outreg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (go & has_res),
		.res_in   (res),
		.dn_stall (dn_stall),
		.free     (out_free),
		.dn_valid (dn_valid),
		.res_out  (res_out)
	);

	assign kind         = res_out.kind;
	assign out_byte     = res_out.out_byte;
	assign frame_length = res_out.frame_length;
	assign first_frame  = res_out.first_frame;

endmodule
`default_nettype wire

>>> rtl/core/lmfd_ctrl.sv
`default_nettype none
// Frame parser: state registers plus one step of next-state logic per word.
module lmfd_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              go,
	input  wire  [7:0]       byte_s1,
	output logic             has_res,
	output lmfd_pkg::res_t   res
);
	import lmfd_pkg::*;

	phase_t      phase_q, phase_n;
	logic [7:0]  held_q, held_n;
	logic [15:0] hdr_q, hdr_n;
	logic [15:0] ftr_q, ftr_n;
	logic        learned_q, learned_n;
	logic [15:0] len_q, len_n;
	logic [15:0] left_q, left_n;
	logic [15:0] word;
	logic [15:0] len_full;

	always_comb begin
		phase_n   = phase_q;
		held_n    = held_q;
		hdr_n     = hdr_q;
		ftr_n     = ftr_q;
		learned_n = learned_q;
		len_n     = len_q;
		left_n    = left_q;
		has_res   = 1'b0;
		word      = {byte_s1, held_q};
		len_full  = {byte_s1, len_q[7:0]} & LEN_MASK;
		res.kind         = K_PAY;
		res.out_byte     = 8'h00;
		res.frame_length = len_q;
		res.first_frame  = ~learned_q;
		case (phase_q)
			PH_HDR1: begin
				if (learned_q && word != hdr_q) begin
					has_res          = 1'b1;
					res.kind         = K_DROP;
					res.frame_length = 16'h0000;
					held_n           = byte_s1;
				end else begin
					if (!learned_q)
						hdr_n = word;
					phase_n = PH_LEN0;
				end
			end
			PH_LEN0: begin
				len_n   = {8'h00, byte_s1};
				phase_n = PH_LEN1;
			end
			PH_LEN1: begin
				len_n   = len_full;
				left_n  = len_full;
				phase_n = (len_full == 16'h0000) ? PH_FTR0 : PH_PAY;
			end
			PH_PAY: begin
				has_res      = 1'b1;
				res.out_byte = byte_s1;
				left_n       = left_q - 16'd1;
				if (left_q == 16'd1)
					phase_n = PH_FTR0;
			end
			PH_FTR0: begin
				held_n  = byte_s1;
				phase_n = PH_FTR1;
			end
			PH_FTR1: begin
				has_res = 1'b1;
				if (!learned_q) begin
					ftr_n     = word;
					learned_n = 1'b1;
					res.kind  = K_GOOD;
				end else begin
					res.kind = (word == ftr_q) ? K_GOOD : K_BAD;
				end
				phase_n = PH_HDR0;
			end
			default: begin
				// first header byte, and the unused code
				held_n  = byte_s1;
				phase_n = PH_HDR1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			held_q    <= 8'h00;
			hdr_q     <= 16'h0000;
			ftr_q     <= 16'h0000;
			learned_q <= 1'b0;
			len_q     <= 16'h0000;
			left_q    <= 16'h0000;
		end else if (go) begin
			phase_q   <= phase_n;
			held_q    <= held_n;
			hdr_q     <= hdr_n;
			ftr_q     <= ftr_n;
			learned_q <= learned_n;
			len_q     <= len_n;
			left_q    <= left_n;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/lmfd_outreg.sv
`default_nettype none
// Result register; loads only when empty or being drained.
module lmfd_outreg (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              load,
	input  lmfd_pkg::res_t   res_in,
	input  wire              dn_stall,
	output logic             free,
	output logic             dn_valid,
	output lmfd_pkg::res_t   res_out
);
	import lmfd_pkg::*;

	logic valid_q;
	res_t res_q;

	assign free     = ~valid_q | ~dn_stall;
	assign dn_valid = valid_q;
	assign res_out  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load)
			res_q <= res_in;
	end

endmodule
`default_nettype wire

>>> rtl/core/lmfd_chk.sv
`default_nettype none
module lmfd_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        up_stall,
	input wire        dn_valid,
	input wire        dn_stall,
	input wire [1:0]  kind,
	input wire [7:0]  out_byte,
	input wire [15:0] frame_length,
	input wire        first_frame
);
	import lmfd_pkg::*;

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dn_valid && kind != K_PAY |-> out_byte == 8'h00)
		else $error("non-payload result carries a byte");

	a_drop_len: assert property (@(posedge clk) disable iff (!arst_n)
		dn_valid && kind == K_DROP |-> frame_length == 16'h0000)
		else $error("dropped header byte carries a length");

	a_drop_learned: assert property (@(posedge clk) disable iff (!arst_n)
		dn_valid && kind == K_DROP |-> !first_frame)
		else $error("header drop before markers learned");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dn_valid && dn_stall |=> dn_valid && $stable(kind) && $stable(out_byte)
			&& $stable(frame_length) && $stable(first_frame))
		else $error("stalled result changed");

	// input is only held back by a full, stalled output register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		up_stall |-> dn_valid && dn_stall)
		else $error("input stalled without downstream stall");

endmodule

bind learned_marker_frame_deframer_core lmfd_chk u_chk (.*);
`default_nettype wire
